// File: src/rot_pkg.sv
// Package for the retransmit outbox table: item codes, entry layout,
// sequencer states and port widths. No dependencies.
package rot_pkg;

  localparam int SLOTS_DEF  = 8;
  localparam int MAX_OUT    = 8;
  localparam int CNT_W      = 4;
  localparam int RT_W       = 20;
  localparam int IN_DATA_W  = 104;
  localparam int OUT_DATA_W = 80;
  localparam int SLOT_W     = 3;

  localparam logic [RT_W-1:0] RT_RESET = 20'd2000;

  typedef enum logic [1:0] {
    ACT_ENQ  = 2'd0,
    ACT_ACK  = 2'd1,
    ACT_TICK = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    RS_RESEND        = 3'd0,
    RS_QUEUED_SENT   = 3'd1,
    RS_QUEUED_HELD   = 3'd2,
    RS_REPLACED_SENT = 3'd3,
    RS_REPLACED_HELD = 3'd4,
    RS_ACKED         = 3'd5,
    RS_ACK_UNKNOWN   = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    CMP_LT  = 2'd0,
    CMP_EQ  = 2'd1,
    CMP_AGE = 2'd2
  } cmp_op_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_RD     = 3'd1,
    S_EV     = 3'd2,
    S_ENQ_WR = 3'd3,
    S_RD2    = 3'd4,
    S_EV2    = 3'd5
  } state_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] uptime;
    logic [6:0]  conf;
    logic [31:0] sent;
  } entry_t;

endpackage

// File: src/rot_cmp.sv
// Shared 32-bit subtract/compare unit used by the S_EV scan steps.
// Depends on rot_pkg.
module rot_cmp (
  input  rot_pkg::cmp_op_t        op,
  input  logic [31:0]             a,
  input  logic [31:0]             b,
  input  logic [rot_pkg::RT_W-1:0] lim,
  output logic                    flag
);
  import rot_pkg::*;

  logic [32:0] sub;
  logic [31:0] diff;

  always_comb begin
    sub  = {1'b0, a} - {1'b0, b};
    diff = sub[31:0];
    unique case (op)
      CMP_LT:  flag = sub[32];
      CMP_EQ:  flag = (diff == 32'd0);
      // age taken mod 2^32, flag set while still too young
      CMP_AGE: flag = (diff < {{(32-RT_W){1'b0}}, lim});
      default: flag = 1'b0;
    endcase
  end

endmodule

// File: src/rot_mem.sv
// Slot entry memory: one write port, one read port with registered data.
// Depends on rot_pkg.
module rot_mem #(
  parameter int SLOTS = rot_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(SLOTS)-1:0] waddr,
  input  rot_pkg::entry_t          wdata,
  input  logic [$clog2(SLOTS)-1:0] raddr,
  output rot_pkg::entry_t          rdata
);
  import rot_pkg::*;

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/retransmit_outbox_table.sv
// Retransmit outbox table: scans slots one at a time, each slot visited through a
// read state then an evaluate state. Enqueue scans to the first free slot (all slots
// when full), then writes. Ack scans to the match (all slots on a miss). Tick with
// link up: a due scan over all slots, then a resend pass up to the last due slot. A
// tick with the link down or an unused action is dropped; output stalls hold the sequencer.
// Reset clears the used bits, the sequencer and the output; retransmit_ms = 2000.
module retransmit_outbox_table #(
  parameter int SLOTS = rot_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // seq[31:0], event_uptime[63:32], confidence_code[70:64], now_ms[102:71], link_up[103]
  input  logic [rot_pkg::IN_DATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [1:0]                     in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // slot[2:0], out_seq[34:3], out_uptime[66:35], out_confidence[73:67], zero[79:74]
  output logic [rot_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[2:0]
  output logic [2:0]                     out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_we,
  input  logic [rot_pkg::RT_W-1:0]       cfg_wdata
);
  import rot_pkg::*;

  localparam int IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  state_t state_r, state_nxt;
  logic [RT_W-1:0] rt_r;
  logic [SLOTS-1:0] used_r, used_nxt;

  action_t act_r, act_nxt;
  logic [31:0] seq_in_r, seq_in_nxt;
  logic [31:0] up_in_r, up_in_nxt;
  logic [6:0]  conf_in_r, conf_in_nxt;
  logic [31:0] now_r, now_nxt;
  logic        link_r, link_nxt;

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] pick_r, pick_nxt;
  logic [31:0]      min_r, min_nxt;
  logic             replaced_r, replaced_nxt;
  logic [SLOTS-1:0] due_r, due_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] emit_r, emit_nxt;

  logic        out_valid_r, out_valid_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [2:0]  out_slot_r, out_slot_nxt;
  logic [31:0] out_seq_r, out_seq_nxt;
  logic [31:0] out_uptime_r, out_uptime_nxt;
  logic [6:0]  out_conf_r, out_conf_nxt;
  logic        out_last_r, out_last_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  entry_t           mem_wdata;
  entry_t           rd;

  cmp_op_t cmp_op;
  logic [31:0] cmp_a, cmp_b;
  logic cmp_flag;

  logic accept, out_free, is_last, free_hit, match, due, final_emit;
  action_t in_act;

  rot_mem #(.SLOTS(SLOTS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (idx_r),
    .rdata (rd)
  );

  rot_cmp u_cmp (
    .op   (cmp_op),
    .a    (cmp_a),
    .b    (cmp_b),
    .lim  (rt_r),
    .flag (cmp_flag)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign in_act     = action_t'(in_tuser);
  assign out_free   = !out_valid_r || out_tready;
  assign is_last    = (idx_r == LAST_IDX);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_conf_r, out_uptime_r, out_seq_r, out_slot_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    unique case (act_r)
      ACT_ENQ: begin
        cmp_op = CMP_LT;
        cmp_a  = rd.seq;
        cmp_b  = min_r;
      end
      ACT_TICK: begin
        cmp_op = CMP_AGE;
        cmp_a  = now_r;
        cmp_b  = rd.sent;
      end
      default: begin
        cmp_op = CMP_EQ;
        cmp_a  = rd.seq;
        cmp_b  = seq_in_r;
      end
    endcase
  end

  assign free_hit   = !used_r[idx_r];
  assign match      = used_r[idx_r] && cmp_flag;
  // never-sent entries carry a zero stamp
  assign due        = used_r[idx_r] && (cnt_r < CNT_W'(MAX_OUT)) &&
                      ((rd.sent == 32'd0) || !cmp_flag);
  assign final_emit = ((emit_r + CNT_W'(1)) == cnt_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          priority if (in_act == ACT_ENQ || in_act == ACT_ACK) begin
            state_nxt = S_RD;
          end else if (in_act == ACT_TICK && in_tdata[103]) begin
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_RD: state_nxt = S_EV;
      S_EV: begin
        unique case (act_r)
          ACT_ENQ:  state_nxt = (free_hit || is_last) ? S_ENQ_WR : S_RD;
          ACT_ACK: begin
            if (match || is_last) state_nxt = out_free ? S_IDLE : S_EV;
            else state_nxt = S_RD;
          end
          ACT_TICK: begin
            if (is_last) state_nxt = (cnt_r != '0 || due) ? S_RD2 : S_IDLE;
            else state_nxt = S_RD;
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_ENQ_WR: state_nxt = out_free ? S_IDLE : S_ENQ_WR;
      S_RD2:    state_nxt = S_EV2;
      S_EV2: begin
        if (due_r[idx_r]) begin
          if (out_free) state_nxt = final_emit ? S_IDLE : S_RD2;
          else state_nxt = S_EV2;
        end else begin
          state_nxt = S_RD2;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath and output controls
  always_comb begin
    act_nxt        = act_r;
    seq_in_nxt     = seq_in_r;
    up_in_nxt      = up_in_r;
    conf_in_nxt    = conf_in_r;
    now_nxt        = now_r;
    link_nxt       = link_r;
    idx_nxt        = idx_r;
    pick_nxt       = pick_r;
    min_nxt        = min_r;
    replaced_nxt   = replaced_r;
    due_nxt        = due_r;
    cnt_nxt        = cnt_r;
    emit_nxt       = emit_r;
    used_nxt       = used_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r;
    mem_wdata      = rd;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_seq_nxt    = out_seq_r;
    out_uptime_nxt = out_uptime_r;
    out_conf_nxt   = out_conf_r;
    out_last_nxt   = out_last_r;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          act_nxt      = in_act;
          seq_in_nxt   = in_tdata[31:0];
          up_in_nxt    = in_tdata[63:32];
          conf_in_nxt  = in_tdata[70:64];
          now_nxt      = in_tdata[102:71];
          link_nxt     = in_tdata[103];
          idx_nxt      = '0;
          replaced_nxt = 1'b0;
          due_nxt      = '0;
          cnt_nxt      = '0;
          emit_nxt     = '0;
        end
      end
      S_EV: begin
        unique case (act_r)
          ACT_ENQ: begin
            if (free_hit) begin
              pick_nxt     = idx_r;
              replaced_nxt = 1'b0;
            end else begin
              // table full so far: track lowest seq, first index wins ties
              if (idx_r == '0 || cmp_flag) begin
                min_nxt  = rd.seq;
                pick_nxt = idx_r;
              end
              replaced_nxt = 1'b1;
              if (!is_last) idx_nxt = idx_r + IDX_W'(1);
            end
          end
          ACT_ACK: begin
            if (match) begin
              if (out_free) begin
                used_nxt[idx_r] = 1'b0;
                out_valid_nxt   = 1'b1;
                out_status_nxt  = RS_ACKED;
                out_slot_nxt    = 3'(idx_r);
                out_seq_nxt     = seq_in_r;
                out_uptime_nxt  = rd.uptime;
                out_conf_nxt    = rd.conf;
                out_last_nxt    = 1'b1;
              end
            end else if (is_last) begin
              if (out_free) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = RS_ACK_UNKNOWN;
                out_slot_nxt   = 3'd0;
                out_seq_nxt    = seq_in_r;
                out_uptime_nxt = 32'd0;
                out_conf_nxt   = 7'd0;
                out_last_nxt   = 1'b1;
              end
            end else begin
              idx_nxt = idx_r + IDX_W'(1);
            end
          end
          ACT_TICK: begin
            if (due) begin
              due_nxt[idx_r] = 1'b1;
              cnt_nxt        = cnt_r + CNT_W'(1);
              mem_we         = 1'b1;
              mem_wdata.sent = now_r;
            end
            idx_nxt = is_last ? '0 : idx_r + IDX_W'(1);
          end
          default: ;
        endcase
      end
      S_ENQ_WR: begin
        if (out_free) begin
          mem_we           = 1'b1;
          mem_waddr        = pick_r;
          mem_wdata.seq    = seq_in_r;
          mem_wdata.uptime = up_in_r;
          mem_wdata.conf   = conf_in_r;
          mem_wdata.sent   = link_r ? now_r : 32'd0;
          used_nxt[pick_r] = 1'b1;
          out_valid_nxt    = 1'b1;
          priority if (replaced_r && link_r) out_status_nxt = RS_REPLACED_SENT;
          else if (replaced_r)               out_status_nxt = RS_REPLACED_HELD;
          else if (link_r)                   out_status_nxt = RS_QUEUED_SENT;
          else                               out_status_nxt = RS_QUEUED_HELD;
          out_slot_nxt   = 3'(pick_r);
          out_seq_nxt    = seq_in_r;
          out_uptime_nxt = up_in_r;
          out_conf_nxt   = conf_in_r;
          out_last_nxt   = 1'b1;
        end
      end
      S_EV2: begin
        if (due_r[idx_r]) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = RS_RESEND;
            out_slot_nxt   = 3'(idx_r);
            out_seq_nxt    = rd.seq;
            out_uptime_nxt = rd.uptime;
            out_conf_nxt   = rd.conf;
            out_last_nxt   = final_emit;
            emit_nxt       = emit_r + CNT_W'(1);
            idx_nxt        = idx_r + IDX_W'(1);
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      rt_r        <= RT_RESET;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        rt_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    seq_in_r     <= seq_in_nxt;
    up_in_r      <= up_in_nxt;
    conf_in_r    <= conf_in_nxt;
    now_r        <= now_nxt;
    link_r       <= link_nxt;
    idx_r        <= idx_nxt;
    pick_r       <= pick_nxt;
    min_r        <= min_nxt;
    replaced_r   <= replaced_nxt;
    due_r        <= due_nxt;
    cnt_r        <= cnt_nxt;
    emit_r       <= emit_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_seq_r    <= out_seq_nxt;
    out_uptime_r <= out_uptime_nxt;
    out_conf_r   <= out_conf_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule

// File: sim/testbench.sv
// Testbench for retransmit_outbox_table: directed and random enqueue/ack/tick
// items, checked against a scoreboard that mirrors the slot table.
// Depends on src/rot_pkg.sv and src/retransmit_outbox_table.sv.
`timescale 1ns / 100ps

module testbench;
  import rot_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  // unused action code, the block accepts and drops it
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    status_t     status;
    logic [2:0]  slot;
    logic [31:0] seq;
    logic [31:0] uptime;
    logic [6:0]  conf;
    logic        last;
  } outbox_result_t;

  class outbox_scoreboard;
    bit               used[SLOTS];
    logic [31:0]      seq_tab[SLOTS];
    logic [31:0]      uptime_tab[SLOTS];
    logic [6:0]       conf_tab[SLOTS];
    logic [31:0]      sent_tab[SLOTS];
    logic [RT_W-1:0]  retransmit;
    outbox_result_t   awaited_results[$];
    int               errors;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      retransmit = RT_RESET;
      errors = 0;
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    function void note_item(logic [1:0] act, logic [31:0] sq, logic [31:0] up,
                            logic [6:0] conf, logic [31:0] now, logic link);
      int             pick;
      int             sent_cnt;
      logic [31:0]    age;
      outbox_result_t r;
      case (act)
        ACT_ENQ: begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++)
            if (!used[i] && pick < 0) pick = i;
          if (pick < 0) begin
            // full: lowest sequence number goes, lowest index on a tie
            pick = 0;
            for (int i = 1; i < SLOTS; i++)
              if (seq_tab[i] < seq_tab[pick]) pick = i;
            r.status = link ? RS_REPLACED_SENT : RS_REPLACED_HELD;
          end else begin
            r.status = link ? RS_QUEUED_SENT : RS_QUEUED_HELD;
          end
          used[pick]       = 1'b1;
          seq_tab[pick]    = sq;
          uptime_tab[pick] = up;
          conf_tab[pick]   = conf;
          sent_tab[pick]   = link ? now : 32'd0;
          r.slot   = pick[2:0];
          r.seq    = sq;
          r.uptime = up;
          r.conf   = conf;
          r.last   = 1'b1;
          awaited_results.push_back(r);
        end
        ACT_ACK: begin
          pick = -1;
          for (int i = 0; i < SLOTS; i++)
            if (pick < 0 && used[i] && seq_tab[i] == sq) pick = i;
          r.seq  = sq;
          r.last = 1'b1;
          if (pick >= 0) begin
            used[pick] = 1'b0;
            r.status = RS_ACKED;
            r.slot   = pick[2:0];
            r.uptime = uptime_tab[pick];
            r.conf   = conf_tab[pick];
          end else begin
            r.status = RS_ACK_UNKNOWN;
            r.slot   = 3'd0;
            r.uptime = 32'd0;
            r.conf   = 7'd0;
          end
          awaited_results.push_back(r);
        end
        ACT_TICK: begin
          sent_cnt = 0;
          if (link) begin
            for (int i = 0; i < SLOTS; i++) begin
              age = now - sent_tab[i];
              // a zero stamp means never sent, always due
              if (used[i] && sent_cnt < MAX_OUT &&
                  (sent_tab[i] == 32'd0 || age >= {12'd0, retransmit})) begin
                sent_tab[i] = now;
                r.status = RS_RESEND;
                r.slot   = i[2:0];
                r.seq    = seq_tab[i];
                r.uptime = uptime_tab[i];
                r.conf   = conf_tab[i];
                r.last   = 1'b0;
                awaited_results.push_back(r);
                sent_cnt++;
              end
            end
            if (sent_cnt > 0) awaited_results[awaited_results.size()-1].last = 1'b1;
          end
        end
        default: ;
      endcase
    endfunction

    task check_result(logic [2:0] st, logic [OUT_DATA_W-1:0] d, logic lst);
      outbox_result_t e;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result status %0d slot %0d seq %h", st, d[2:0], d[34:3]));
        return;
      end
      e = awaited_results.pop_front();
      if (st !== e.status)
        report($sformatf("status %0d, expected %0d", st, e.status));
      if (d[2:0] !== e.slot)
        report($sformatf("slot %0d, expected %0d", d[2:0], e.slot));
      if (d[34:3] !== e.seq)
        report($sformatf("seq %h, expected %h", d[34:3], e.seq));
      if (d[66:35] !== e.uptime)
        report($sformatf("uptime %h, expected %h", d[66:35], e.uptime));
      if (d[73:67] !== e.conf)
        report($sformatf("confidence %0d, expected %0d", d[73:67], e.conf));
      if (lst !== e.last)
        report($sformatf("tlast %b, expected %b", lst, e.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]            out_tuser;
  logic                  out_tlast;
  logic                  cfg_we = 1'b0;
  logic [RT_W-1:0]       cfg_wdata = '0;

  outbox_scoreboard sb = new();
  int               send_idle = 0;
  int               recv_idle = 0;
  logic [31:0]      clock_ms;
  logic [31:0]      next_seq;

  retransmit_outbox_table #(.SLOTS(SLOTS)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata, out_tlast);
  end

  task automatic drive_item(logic [1:0] act, logic [31:0] sq, logic [31:0] up,
                            logic [6:0] conf, logic [31:0] now, logic link);
    if ($urandom_range(0, 99) < send_idle) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      while ($urandom_range(0, 99) < send_idle) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {link, now, conf, up, sq};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(act, sq, up, conf, now, link);
  endtask

  // drop valid, let every result drain and the last scan finish
  task automatic quiesce();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.awaited_results.size() != 0) @(posedge clk);
    repeat (4 * SLOTS + 32) @(posedge clk);
  endtask

  task automatic write_retransmit(logic [RT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    sb.retransmit = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_items(int count);
    int          done;
    int          roll;
    int          idx;
    logic [1:0]  act;
    logic [31:0] sq;
    logic [6:0]  conf;
    logic        link;
    done = 0;
    while (done < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 5) clock_ms = $urandom();
      else if (roll < 8) clock_ms = 32'd0;
      else if (roll < 20) clock_ms = clock_ms + $urandom_range(1000, 1200000);
      else clock_ms = clock_ms + $urandom_range(0, 400);
      link = ($urandom_range(0, 99) < 85);
      conf = ($urandom_range(0, 99) < 70) ? 7'($urandom_range(0, 100))
                                          : 7'($urandom_range(0, 127));
      roll = $urandom_range(0, 99);
      sq = $urandom();
      if (roll < 5) begin
        act = ACT_NONE;
      end else if (roll < 42) begin
        act = ACT_ENQ;
        roll = $urandom_range(0, 99);
        if (roll < 85) begin
          next_seq = next_seq + 32'd1;
          sq = next_seq;
        end else if (roll < 92) begin
          idx = $urandom_range(0, SLOTS - 1);
          if (sb.used[idx]) sq = sb.seq_tab[idx];
        end
      end else if (roll < 70) begin
        act = ACT_ACK;
        if ($urandom_range(0, 99) < 80) begin
          idx = $urandom_range(0, SLOTS - 1);
          for (int i = 0; i < SLOTS; i++)
            if (sb.used[(idx + i) % SLOTS]) sq = sb.seq_tab[(idx + i) % SLOTS];
        end
      end else begin
        act = ACT_TICK;
      end
      drive_item(act, sq, $urandom(), conf, clock_ms, link);
      if (act != ACT_NONE) done++;
    end
  endtask

  initial begin
    logic [RT_W-1:0] rt_vals[6];
    rt_vals = '{20'd0, 20'hFFFFF, 20'd1, 20'($urandom_range(100, 5000)), 20'd2000, 20'd65535};
    clock_ms = $urandom();
    next_seq = $urandom();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle = 38;
    recv_idle = 65;
    // directed part, reset value of the retransmit interval
    drive_item(ACT_TICK, 32'd0, 32'd0, 7'd0, 32'd1000, 1'b1);       // empty table
    drive_item(ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'h7F, 32'hFFFF_FFFF, 1'b1);
    drive_item(ACT_ACK, 32'hFFFF_FFFF, 32'd0, 7'd0, 32'd1000, 1'b1); // no match
    drive_item(ACT_ENQ, 32'd100, 32'hFFFF_FFFF, 7'd127, 32'd0, 1'b1); // stamped zero
    drive_item(ACT_TICK, 32'd0, 32'd0, 7'd0, 32'd5, 1'b0);          // link down
    drive_item(ACT_TICK, 32'd0, 32'd0, 7'd0, 32'd10, 1'b1);         // zero stamp resent
    drive_item(ACT_TICK, 32'd0, 32'd0, 7'd0, 32'd11, 1'b1);         // not yet due
    drive_item(ACT_ENQ, 32'd50, 32'd0, 7'd0, 32'd20, 1'b0);
    drive_item(ACT_ENQ, 32'd7, 32'd1, 7'd100, 32'd30, 1'b1);
    drive_item(ACT_ENQ, 32'd7, 32'd2, 7'd101, 32'd40, 1'b0);
    drive_item(ACT_ENQ, 32'd200, 32'h5555_5555, 7'h55, 32'd50, 1'b1);
    drive_item(ACT_ENQ, 32'd300, 32'hAAAA_AAAA, 7'h2A, 32'd51, 1'b1);
    drive_item(ACT_ENQ, 32'd400, 32'd3, 7'd3, 32'd52, 1'b1);
    drive_item(ACT_ENQ, 32'hFFFF_FFFF, 32'd4, 7'd4, 32'd53, 1'b1);
    drive_item(ACT_ENQ, 32'd1000, 32'd5, 7'd5, 32'd60, 1'b1);       // full, equal lows
    drive_item(ACT_ENQ, 32'd1001, 32'd6, 7'd6, 32'd70, 1'b0);       // full, held
    drive_item(ACT_TICK, 32'd0, 32'd0, 7'd0, 32'd2010, 1'b1);
    drive_item(ACT_TICK, 32'd0, 32'd0, 7'd0, 32'hFFFF_FFF0, 1'b1);
    drive_item(ACT_ENQ, 32'd0, 32'd0, 7'd0, 32'hFFFF_FFFF, 1'b1);
    drive_item(ACT_TICK, 32'd0, 32'd0, 7'd0, 32'h0000_0200, 1'b1);  // age wraps, not due
    drive_item(ACT_TICK, 32'd0, 32'd0, 7'd0, 32'h0000_0800, 1'b1);  // age wraps, due
    drive_item(ACT_ACK, 32'd100, 32'd0, 7'd0, 32'h0000_0900, 1'b1);
    drive_item(ACT_ACK, 32'd100, 32'd0, 7'd0, 32'h0000_0901, 1'b1); // already freed
    drive_item(ACT_ACK, 32'd0, 32'd0, 7'd0, 32'h0000_0902, 1'b1);

    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin send_idle = 38; recv_idle = 65; end
        1: begin send_idle = 65; recv_idle = 38; end
        default: begin send_idle = 0; recv_idle = 0; end
      endcase
      quiesce();
      write_retransmit(rt_vals[p]);
      random_items(20);
    end

    quiesce();
    if (sb.errors == 0 && sb.awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
